// ----- hw/rtl/xfpc_pkg.sv -----
// Package for the XOR framed packet checker.
// Payload structs, classified byte type, character constants and status codes.
// No dependencies.
package xfpc_pkg;

  localparam int unsigned QDepthDefault = 4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [5:0] LEN_MASK  = 6'h3F;
  localparam logic [6:0] LEN_BIAS  = 7'd4;

  localparam logic [2:0] ST_GOOD_DOLLAR = 3'd0;
  localparam logic [2:0] ST_VV          = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM     = 3'd3;
  localparam logic [2:0] ST_NO_CR       = 3'd4;
  localparam logic [2:0] ST_NO_LF       = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [2:0] status_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       is_v;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

endpackage

// ----- hw/rtl/xfpc_front.sv -----
// Front end of the checker: input handshake and per-byte character classification.
// Depends on xfpc_pkg.
module xfpc_front import xfpc_pkg::*; (
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     q_push,
  output cls_t     q_data,
  input  logic     q_full
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.data_byte   = in_data.data_byte;
    q_data.frame_start = in_data.frame_start;
    q_data.is_v        = (in_data.data_byte == CH_V);
    q_data.is_dollar   = (in_data.data_byte == CH_DOLLAR);
    q_data.is_cr       = (in_data.data_byte == CH_CR);
    q_data.is_lf       = (in_data.data_byte == CH_LF);
  end

endmodule

// ----- hw/rtl/xfpc_fifo.sv -----
// Short queue of classified bytes between front and back ends.
// Depends on xfpc_pkg.
module xfpc_fifo import xfpc_pkg::*; #(
  parameter int unsigned DEPTH = QDepthDefault
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cls_t wr_data,
  output logic full,
  input  logic rd_en,
  output cls_t rd_data,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cls_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/xfpc_back.sv -----
// Back end of the checker: frame tracking, XOR sum, verdict and result register.
// Depends on xfpc_pkg.
module xfpc_back import xfpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cls_t      q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_data,
  output logic      empty,
  input  logic      pop
);

  logic [6:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [6:0] len_r, len_nxt;
  logic       active_r, active_nxt;
  logic       fv_r, fv_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic       emit;
  logic       emit_valid;
  logic [2:0] emit_code;
  logic [6:0] pos_cur, len_cur;
  logic [7:0] xor_cur;
  logic       fv_cur;
  logic       act_cur;

  assign q_pop    = !q_empty && (!out_valid_r || pop);
  assign out_data = out_r;
  assign empty    = !out_valid_r;

  always_comb begin
    pos_cur    = q_data.frame_start ? '0 : pos_r;
    xor_cur    = q_data.frame_start ? '0 : xor_r;
    len_cur    = q_data.frame_start ? '0 : len_r;
    fv_cur     = q_data.frame_start ? 1'b0 : fv_r;
    act_cur    = q_data.frame_start || active_r;

    pos_nxt    = pos_r;
    xor_nxt    = xor_r;
    len_nxt    = len_r;
    fv_nxt     = fv_r;
    active_nxt = active_r;
    emit       = 1'b0;
    emit_valid = 1'b0;
    emit_code  = ST_BAD_HEADER;

    if (q_pop) begin
      pos_nxt    = pos_cur;
      xor_nxt    = xor_cur;
      len_nxt    = len_cur;
      fv_nxt     = fv_cur;
      active_nxt = act_cur;
      if (act_cur) begin
        pos_nxt = pos_cur + 7'd1;
        if (pos_cur == 7'd0) begin
          if (q_data.is_v) begin
            fv_nxt = 1'b1;
          end else if (q_data.is_dollar) begin
            fv_nxt = 1'b0;
          end else begin
            emit = 1'b1;
          end
        end else if (pos_cur == 7'd1) begin
          if (fv_cur) begin
            emit       = 1'b1;
            emit_valid = q_data.is_v;
            emit_code  = q_data.is_v ? ST_VV : ST_BAD_HEADER;
          end else if (!q_data.is_dollar) begin
            emit = 1'b1;
          end
        end else if (pos_cur <= 7'd5 || pos_cur < 7'd2 + len_cur) begin
          if (pos_cur == 7'd5) begin
            len_nxt = {1'b0, q_data.data_byte[5:0] & LEN_MASK} + LEN_BIAS;
          end
          xor_nxt = xor_cur ^ q_data.data_byte;
        end else if (pos_cur == 7'd2 + len_cur) begin
          if (q_data.data_byte != xor_cur) begin
            emit      = 1'b1;
            emit_code = ST_BAD_SUM;
          end
        end else if (pos_cur == 7'd3 + len_cur) begin
          if (!q_data.is_cr) begin
            emit      = 1'b1;
            emit_code = ST_NO_CR;
          end
        end else begin
          emit       = 1'b1;
          emit_valid = q_data.is_lf;
          emit_code  = q_data.is_lf ? ST_GOOD_DOLLAR : ST_NO_LF;
        end
        if (emit) begin
          active_nxt = 1'b0;
        end
      end
    end

    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.frame_valid = emit_valid;
      out_nxt.status_code = emit_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      xor_r       <= '0;
      len_r       <= '0;
      active_r    <= 1'b0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      len_r       <= len_nxt;
      active_r    <= active_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// ----- hw/rtl/xor_framed_packet_checker.sv -----
// Top level of the XOR framed packet checker.
// Depends on xfpc_pkg, xfpc_front, xfpc_fifo, xfpc_back.
//
// Accepts one received byte per cycle while full is low on a queue-style
// port (push/full) and gives one verdict per frame on a queue-style result
// port (empty/pop). A frame opens on a byte flagged frame_start: a "VV"
// header is accepted at once; a "$$" header is followed by a length in byte
// 5 (low six bits plus four), that many XORed bytes from byte 2, a checksum
// byte, CR and LF. Sustained rate is one byte per cycle while each verdict
// is popped as it appears, set by the frame tracking step in the back end.
// A verdict reaches the result port through the byte queue and then the
// result register: the byte is first written into the QUEUE_DEPTH-entry
// byte queue, and the back end writes the result register at the edge where
// it reads the byte. When results are not popped, the queue absorbs up to QUEUE_DEPTH further bytes before full rises.
module xor_framed_packet_checker import xfpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic q_push, q_full, q_pop, q_empty;
  cls_t q_wr_data, q_rd_data;

  xfpc_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  xfpc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  xfpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
